// ===== hdl/pws_pkg.sv =====
// Package for the perspective world-to-screen block: shared types and constants.
// Used by every module of the block.
`default_nettype none
package pws_pkg;

    // Numerator width: offset magnitude times focal length
    localparam int NumW = 82;
    // Quotient width: numerator over a depth of at least 2^30
    localparam int QuoW = 52;
    // Depth and magnitude width
    localparam int MagW = 50;
    // Q.30 value of 1.0
    localparam logic signed [50:0] DEPTH_ONE = 51'sd1 << 30;

    // APB register indexes
    localparam logic [2:0] REG_CAM_X   = 3'd0;
    localparam logic [2:0] REG_CAM_Y   = 3'd1;
    localparam logic [2:0] REG_CAM_Z   = 3'd2;
    localparam logic [2:0] REG_AXIS_F  = 3'd3;
    localparam logic [2:0] REG_AXIS_R  = 3'd4;
    localparam logic [2:0] REG_AXIS_U  = 3'd5;
    localparam logic [2:0] REG_FOCAL   = 3'd6;
    localparam logic [2:0] REG_CENTER  = 3'd7;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [47:0]        axis_forward;
        logic [47:0]        axis_right;
        logic [47:0]        axis_up;
        logic [31:0]        focal;
        logic [63:0]        center;
    } t_cfg;

    // One division job handed from the front to the back
    typedef struct packed {
        logic [NumW-1:0] num_lat;
        logic [NumW-1:0] num_vert;
        logic [MagW-1:0] depth;
        logic            neg_lat;
        logic            neg_vert;
    } t_div_job;

endpackage
`default_nettype wire

// ===== hdl/pws_if.sv =====
// Valid/ready channel interfaces for world points in and screen points out.
// Depends on nothing.
`default_nettype none
interface pws_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface pws_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    modport source (output valid, screen_x, screen_y, input ready);
    modport sink   (input valid, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

// ===== hdl/pws_front.sv =====
// Front pipeline: camera offset, axis dot products, depth clamp, numerator products.
// Depends on pws_pkg and pws_in_if.
`default_nettype none
module pws_front import pws_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    pws_in_if.sink     i_pt,
    output t_div_job   o_job,
    output logic       o_valid,
    input  wire logic  i_ready
);

    logic [5:0] r_v;
    logic       en;

    // advance whenever the last stage is empty or drains
    assign en         = !r_v[5] || i_ready;
    assign i_pt.ready = en;
    assign o_valid    = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], i_pt.valid};
        end
    end

    // stage 1: offset from camera
    logic signed [32:0] r_d [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0] <= 33'(i_pt.point_x) - 33'(i_cfg.cam_x);
            r_d[1] <= 33'(i_pt.point_y) - 33'(i_cfg.cam_y);
            r_d[2] <= 33'(i_pt.point_z) - 33'(i_cfg.cam_z);
        end
    end

    // stage 2: nine component products, axes right, up, forward
    logic [47:0] ax [3];
    assign ax[0] = i_cfg.axis_right;
    assign ax[1] = i_cfg.axis_up;
    assign ax[2] = i_cfg.axis_forward;

    logic signed [48:0] r_p [9];
    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar c = 0; c < 3; c++) begin : g_comp
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_p[a*3+c] <= 49'(r_d[c]) * 49'($signed(ax[a][16*c +: 16]));
                end
            end
        end
    end

    // stage 3: dot products
    logic signed [50:0] r_lat, r_vert, r_dep;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat  <= 51'(r_p[0]) + 51'(r_p[1]) + 51'(r_p[2]);
            r_vert <= 51'(r_p[3]) + 51'(r_p[4]) + 51'(r_p[5]);
            r_dep  <= 51'(r_p[6]) + 51'(r_p[7]) + 51'(r_p[8]);
        end
    end

    // stage 4: magnitudes and clamped depth
    logic [MagW-1:0] r4_ml, r4_mv, r4_d;
    logic            r4_sl, r4_sv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sl <= r_lat[50];
            r4_sv <= r_vert[50];
            r4_ml <= r_lat[50]  ? MagW'(-r_lat)  : MagW'(r_lat);
            r4_mv <= r_vert[50] ? MagW'(-r_vert) : MagW'(r_vert);
            r4_d  <= (r_dep < DEPTH_ONE) ? MagW'(DEPTH_ONE) : MagW'(r_dep);
        end
    end

    // stage 5: partial products of magnitude and focal length
    logic [56:0]     r5_l0, r5_l1, r5_v0, r5_v1;
    logic [MagW-1:0] r5_d;
    logic            r5_sl, r5_sv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_l0 <= 57'(r4_ml[24:0]) * 57'(i_cfg.focal);
            r5_l1 <= 57'(r4_ml[49:25]) * 57'(i_cfg.focal);
            r5_v0 <= 57'(r4_mv[24:0]) * 57'(i_cfg.focal);
            r5_v1 <= 57'(r4_mv[49:25]) * 57'(i_cfg.focal);
            r5_d  <= r4_d;
            r5_sl <= r4_sl;
            r5_sv <= r4_sv;
        end
    end

    // stage 6: combine into full numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_job.num_lat  <= NumW'(r5_l0) + (NumW'(r5_l1) << 25);
            o_job.num_vert <= NumW'(r5_v0) + (NumW'(r5_v1) << 25);
            o_job.depth    <= r5_d;
            o_job.neg_lat  <= r5_sl;
            o_job.neg_vert <= r5_sv;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pws_fifo.sv =====
// Four-entry job queue between the front and back pipelines.
// Depends on pws_pkg.
`default_nettype none
module pws_fifo import pws_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_job i_job,
    input  wire logic     i_valid,
    output logic          o_ready,
    output t_div_job      o_job,
    output logic          o_valid,
    input  wire logic     i_ready
);

    t_div_job   r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;
    // accept while not full, or when a beat leaves in the same cycle
    assign o_ready = (r_cnt != 3'd4) || pop;
    assign push    = i_valid && o_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pws_back.sv =====
// Back pipeline: one quotient bit per stage for both offsets, then center add and saturate.
// Depends on pws_pkg and pws_out_if.
`default_nettype none
module pws_back import pws_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_div_job i_job,
    input  wire logic     i_valid,
    output logic          o_ready,
    pws_out_if.source     o_scr
);

    localparam int Stages = QuoW;

    logic            en;
    logic            r_ov;
    logic [Stages-1:0] r_v;

    t_div_job        r_job [Stages];
    logic [MagW-1:0] r_rl [Stages];
    logic [MagW-1:0] r_rv [Stages];
    logic [QuoW-1:0] r_ql [Stages];
    logic [QuoW-1:0] r_qv [Stages];

    assign en       = !r_ov || o_scr.ready;
    assign o_ready  = en;
    assign o_scr.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[Stages-2:0], i_valid};
            r_ov <= r_v[Stages-1];
        end
    end

    // divide stages: stage s resolves quotient bit QuoW-1-s
    for (genvar s = 0; s < Stages; s++) begin : g_div
        t_div_job        jin;
        logic [MagW-1:0] rl_in, rv_in;
        logic [QuoW-1:0] ql_in, qv_in;
        logic [MagW:0]   tl, tv;

        if (s == 0) begin : g_first
            assign jin   = i_job;
            assign rl_in = MagW'(i_job.num_lat[NumW-1:QuoW]);
            assign rv_in = MagW'(i_job.num_vert[NumW-1:QuoW]);
            assign ql_in = '0;
            assign qv_in = '0;
        end else begin : g_next
            assign jin   = r_job[s-1];
            assign rl_in = r_rl[s-1];
            assign rv_in = r_rv[s-1];
            assign ql_in = r_ql[s-1];
            assign qv_in = r_qv[s-1];
        end

        // shift in the next numerator bit
        assign tl = {rl_in, jin.num_lat[QuoW-1-s]};
        assign tv = {rv_in, jin.num_vert[QuoW-1-s]};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_job[s] <= jin;
                if (tl >= {1'b0, jin.depth}) begin
                    r_rl[s] <= MagW'(tl - {1'b0, jin.depth});
                    r_ql[s] <= {ql_in[QuoW-2:0], 1'b1};
                end else begin
                    r_rl[s] <= MagW'(tl);
                    r_ql[s] <= {ql_in[QuoW-2:0], 1'b0};
                end
                if (tv >= {1'b0, jin.depth}) begin
                    r_rv[s] <= MagW'(tv - {1'b0, jin.depth});
                    r_qv[s] <= {qv_in[QuoW-2:0], 1'b1};
                end else begin
                    r_rv[s] <= MagW'(tv);
                    r_qv[s] <= {qv_in[QuoW-2:0], 1'b0};
                end
            end
        end
    end

    // apply signs, add lateral to center x, subtract vertical from center y, saturate
    logic signed [53:0] term_l, term_v, sum_x, sum_y;
    logic signed [31:0] n_x, n_y;
    t_div_job           jl;

    assign jl     = r_job[Stages-1];
    assign term_l = jl.neg_lat  ? -$signed(54'(r_ql[Stages-1])) : $signed(54'(r_ql[Stages-1]));
    assign term_v = jl.neg_vert ? -$signed(54'(r_qv[Stages-1])) : $signed(54'(r_qv[Stages-1]));
    assign sum_x  = $signed(54'(i_cfg.center[31:0])) + term_l;
    assign sum_y  = $signed(54'(i_cfg.center[63:32])) - term_v;

    always_comb begin
        if (sum_x > 54'sd2147483647)       n_x = 32'sh7fffffff;
        else if (sum_x < -54'sd2147483648) n_x = 32'sh80000000;
        else                               n_x = 32'(sum_x);
        if (sum_y > 54'sd2147483647)       n_y = 32'sh7fffffff;
        else if (sum_y < -54'sd2147483648) n_y = 32'sh80000000;
        else                               n_y = 32'(sum_y);
    end

    logic signed [31:0] r_x, r_y;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end
    assign o_scr.screen_x = r_x;
    assign o_scr.screen_y = r_y;

endmodule
`default_nettype wire

// ===== hdl/perspective_world_to_screen.sv =====
// Top level of the perspective world-to-screen block: APB registers, front, queue, back.
// Depends on pws_pkg, pws_if, pws_front, pws_fifo and pws_back.
//
// Usage:
//   i_pt carries world points (point_x/y/z, signed Q16.16) in valid/ready beats;
//   o_scr carries screen points (screen_x/y, signed Q16.16, saturated).
//   Camera position, axes, focal length and screen center sit in APB registers
//   at byte address 8*index; write them only while no point is in flight.
//   Throughput: one point per cycle while the receiver holds ready high. The path
//   from an accepted input beat to its output beat runs through 6 front stages,
//   the queue, 52 divide stages that each resolve one quotient bit, and one output register.
//   The divide pipeline sets the latency; the 4-entry queue lets the front keep
//   taking beats while the back is stalled, until the queue and front fill.
//   When the receiver holds ready low with a beat on the output, the back freezes and the output beat holds.
//   Reset clears all valid state and loads the default camera registers.
`default_nettype none
module perspective_world_to_screen import pws_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    pws_in_if.sink           i_pt,
    pws_out_if.source        o_scr
);

    t_cfg       r_cfg;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x        <= '0;
            r_cfg.cam_y        <= '0;
            r_cfg.cam_z        <= '0;
            r_cfg.axis_forward <= 48'd16384;
            r_cfg.axis_right   <= 48'd1073741824;
            r_cfg.axis_up      <= 48'd70368744177664;
            r_cfg.focal        <= 32'd62914560;
            r_cfg.center       <= 64'd151996487486668800;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_CAM_X:  r_cfg.cam_x        <= pwdata[31:0];
                REG_CAM_Y:  r_cfg.cam_y        <= pwdata[31:0];
                REG_CAM_Z:  r_cfg.cam_z        <= pwdata[31:0];
                REG_AXIS_F: r_cfg.axis_forward <= pwdata[47:0];
                REG_AXIS_R: r_cfg.axis_right   <= pwdata[47:0];
                REG_AXIS_U: r_cfg.axis_up      <= pwdata[47:0];
                REG_FOCAL:  r_cfg.focal        <= pwdata[31:0];
                REG_CENTER: r_cfg.center       <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (idx)
            REG_CAM_X:  prdata = 64'($unsigned(r_cfg.cam_x));
            REG_CAM_Y:  prdata = 64'($unsigned(r_cfg.cam_y));
            REG_CAM_Z:  prdata = 64'($unsigned(r_cfg.cam_z));
            REG_AXIS_F: prdata = 64'(r_cfg.axis_forward);
            REG_AXIS_R: prdata = 64'(r_cfg.axis_right);
            REG_AXIS_U: prdata = 64'(r_cfg.axis_up);
            REG_FOCAL:  prdata = 64'(r_cfg.focal);
            REG_CENTER: prdata = r_cfg.center;
            default:    prdata = '0;
        endcase
    end

    t_div_job f_job, q_job;
    logic     f_valid, f_ready, q_valid, q_ready;

    pws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pt    (i_pt),
        .o_job   (f_job),
        .o_valid (f_valid),
        .i_ready (f_ready)
    );

    pws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (f_job),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_job   (q_job),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    pws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (q_job),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .o_scr   (o_scr)
    );

endmodule
`default_nettype wire
